// ===== sv/dsi_pkg.sv =====
// Shared types, codes and helpers for the damped spring integrator.
// No dependencies; every other file in the project imports this package.
package dsi_pkg;

  localparam int FIELD_W = 32;  // signed fixed-point value width
  localparam int COEF_W  = 31;  // unsigned coefficient register width
  localparam int TS_W    = 17;  // time step width
  localparam int THR_W   = 16;  // settle threshold width
  localparam int IDX_W   = 3;   // configuration register index width
  localparam int MUL_W   = 33;  // shared multiplier operand width
  localparam int PROD_W  = 66;  // shared multiplier product width
  localparam int ACC_W   = 68;  // wide sum width ahead of saturation

  localparam logic [THR_W-1:0] THR_RESET = 16'd66;

  // Request function codes
  typedef enum logic [1:0] {
    FN_EVAL    = 2'd0,
    FN_TARGET  = 2'd1,
    FN_SCRUB   = 2'd2,
    FN_RESTART = 2'd3
  } func_t;

  // Configuration register indexes
  typedef enum logic [IDX_W-1:0] {
    CFG_MASS      = 3'd0,
    CFG_STIFFNESS = 3'd1,
    CFG_DAMPING   = 3'd2,
    CFG_START_VEL = 3'd3,
    CFG_THRESHOLD = 3'd4
  } cfg_idx_t;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_K,
    ST_MUL_C,
    ST_FORCE,
    ST_DIV_START,
    ST_DIV,
    ST_MUL_ACC,
    ST_VEL,
    ST_MUL_VEL,
    ST_POS,
    ST_SCRUB,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [1:0]                func;
    logic [TS_W-1:0]           time_step;
    logic signed [FIELD_W-1:0] new_target;
    logic signed [FIELD_W-1:0] fraction;
  } in_req_t;

  typedef struct packed {
    logic signed [FIELD_W-1:0] position;
    logic                      settled;
  } out_rsp_t;

  typedef struct packed {
    logic [IDX_W-1:0]   index;
    logic [FIELD_W-1:0] data;
  } cfg_req_t;

  // Effective coefficients, zero mass, stiffness and damping already replaced by defaults
  typedef struct packed {
    logic [COEF_W-1:0]         mass;
    logic [COEF_W-1:0]         stiffness;
    logic [COEF_W-1:0]         damping;
    logic signed [FIELD_W-1:0] start_velocity;
    logic [THR_W-1:0]          threshold;
  } coef_t;

  // Clamp a wide signed value to the signed 32-bit range
  function automatic logic signed [FIELD_W-1:0] sat32(input logic signed [ACC_W-1:0] x);
    logic all_zero;
    logic all_one;
    all_zero = ~|x[ACC_W-1:FIELD_W-1];
    all_one  = &x[ACC_W-1:FIELD_W-1];
    if (all_zero || all_one) begin
      sat32 = x[FIELD_W-1:0];
    end else if (x[ACC_W-1]) begin
      sat32 = {1'b1, {(FIELD_W-1){1'b0}}};
    end else begin
      sat32 = {1'b0, {(FIELD_W-1){1'b1}}};
    end
  endfunction

endpackage

// ===== sv/dsi_in_if.sv =====
// Input request channel: valid, ready and one request payload.
// Depends on dsi_pkg for the payload type.
interface dsi_in_if;
  import dsi_pkg::*;
  logic    valid;
  logic    ready;
  in_req_t req;
  modport source (output valid, output req, input ready);
  modport sink (input valid, input req, output ready);
endinterface

// ===== sv/dsi_out_if.sv =====
// Result channel: valid, ready and one result payload.
// Depends on dsi_pkg for the payload type.
interface dsi_out_if;
  import dsi_pkg::*;
  logic     valid;
  logic     ready;
  out_rsp_t rsp;
  modport source (output valid, output rsp, input ready);
  modport sink (input valid, input rsp, output ready);
endinterface

// ===== sv/dsi_cfg_if.sv =====
// Configuration write channel: valid, ready, register index and data.
// Depends on dsi_pkg for the payload type.
interface dsi_cfg_if;
  import dsi_pkg::*;
  logic     valid;
  logic     ready;
  cfg_req_t req;
  modport source (output valid, output req, input ready);
  modport sink (input valid, input req, output ready);
endinterface

// ===== sv/damped_spring_integrator_top.sv =====
// Damped spring integrator: sequencer around one shared multiplier and a serial divider.
// Evaluate runs the force multiplies, the divide by mass and the velocity and position updates;
// the divide produces one quotient bit per cycle over 32 + FRAC_BITS bits (48 at Q16.16).
// Scrub-mode evaluate skips to the scrub product; restart, target and scrub requests update state in idle.
// One request at a time; the next is accepted once the result sits in the output register.
// Synchronous reset restores the default coefficients, value 0, target 1.0, no scrub.
module damped_spring_integrator_top #(
  parameter int FRAC_BITS = 16
) (
  input  logic      clk,
  input  logic      rst,
  dsi_in_if.sink    in_ch,
  dsi_out_if.source out_ch,
  dsi_cfg_if.sink   cfg_ch
);
  import dsi_pkg::*;

  localparam int DW   = FIELD_W + FRAC_BITS;
  localparam int SA_W = FRAC_BITS + 1;
  localparam logic signed [FIELD_W-1:0] ONE_VAL = FIELD_W'(1) << FRAC_BITS;
  localparam logic [SA_W-1:0]           ONE_SA  = SA_W'(1) << FRAC_BITS;

  state_t state;
  state_t state_next;
  coef_t  coef;

  // Architectural state
  logic signed [FIELD_W-1:0] value_now;
  logic signed [FIELD_W-1:0] velocity_now;
  logic signed [FIELD_W-1:0] target_now;
  logic                      scrub_mode;
  logic [SA_W-1:0]           scrub_amount;

  // Working registers
  logic [TS_W-1:0]           dt;
  logic signed [FIELD_W-1:0] disp;
  logic signed [ACC_W-1:0]   force_part;
  logic signed [FIELD_W-1:0] force_sat;
  logic signed [FIELD_W-1:0] acc;
  logic signed [FIELD_W-1:0] vel_new;
  logic signed [FIELD_W-1:0] pos_new;
  logic                      is_scrub;
  logic                      out_valid;
  logic signed [FIELD_W-1:0] out_pos;
  logic                      out_settled;

  // Shared unit connections
  logic signed [MUL_W-1:0]  mul_a;
  logic signed [MUL_W-1:0]  mul_b;
  logic signed [PROD_W-1:0] mul_p;
  logic signed [ACC_W-1:0]  prod_fl;
  logic                     div_busy;
  logic [DW-1:0]            div_q;
  logic [FIELD_W-1:0]       force_abs;
  logic signed [ACC_W-1:0]  quo_ext;

  // Request decode and settling compare
  logic [1:0]                req_func;
  logic signed [FIELD_W-1:0] frac_in;
  logic [SA_W-1:0]           frac_clamped;
  logic signed [MUL_W:0]     gap;
  logic [MUL_W:0]            gap_abs;
  logic signed [MUL_W-1:0]   vel_ext;
  logic [MUL_W-1:0]          vel_abs;
  logic                      settle_hit;
  logic                      out_free;

  dsi_regs #(.FRAC_BITS(FRAC_BITS)) u_regs (
    .clk    (clk),
    .rst    (rst),
    .cfg_ch (cfg_ch),
    .coef   (coef)
  );

  dsi_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  dsi_div #(.DW(DW)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (state == ST_DIV_START),
    .dividend ({force_abs, {FRAC_BITS{1'b0}}}),
    .divisor  (coef.mass),
    .busy     (div_busy),
    .quotient (div_q)
  );

  // Floor of the rescaled product
  assign prod_fl   = ACC_W'(mul_p >>> FRAC_BITS);
  assign force_abs = force_sat[FIELD_W-1] ? (~force_sat + FIELD_W'(1)) : force_sat;
  assign quo_ext   = $signed({{(ACC_W-DW){1'b0}}, div_q});

  assign req_func = in_ch.req.func;
  assign frac_in  = in_ch.req.fraction;

  // Clamp the scrub fraction to 0..1.0
  always_comb begin
    if (frac_in[FIELD_W-1]) begin
      frac_clamped = '0;
    end else if (frac_in > ONE_VAL) begin
      frac_clamped = ONE_SA;
    end else begin
      frac_clamped = frac_in[SA_W-1:0];
    end
  end

  // Settle when speed and distance are both under the threshold, outside scrub mode
  assign vel_ext    = MUL_W'(vel_new);
  assign vel_abs    = vel_ext[MUL_W-1] ? -vel_ext : vel_ext;
  assign gap        = (MUL_W+1)'(pos_new) - (MUL_W+1)'(target_now);
  assign gap_abs    = gap[MUL_W] ? -gap : gap;
  assign settle_hit = !is_scrub &&
                      (vel_abs < MUL_W'(coef.threshold)) &&
                      (gap_abs < (MUL_W+1)'(coef.threshold));
  assign out_free   = !out_valid || out_ch.ready;

  assign out_ch.valid        = out_valid;
  assign out_ch.rsp.position = out_pos;
  assign out_ch.rsp.settled  = out_settled;

  // Hold the state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Advance the sequencer and steer the multiplier operands
  always_comb begin
    state_next  = state;
    in_ch.ready = 1'b0;
    mul_a       = $signed({{(MUL_W-SA_W){1'b0}}, scrub_amount});
    mul_b       = MUL_W'(target_now);
    case (state)
      ST_IDLE: begin
        in_ch.ready = 1'b1;
        if (in_ch.valid && req_func == FN_EVAL) begin
          state_next = scrub_mode ? ST_SCRUB : ST_MUL_K;
        end
      end
      ST_MUL_K: begin
        mul_a      = $signed({2'b00, coef.stiffness});
        mul_b      = -(MUL_W'(disp));
        state_next = ST_MUL_C;
      end
      ST_MUL_C: begin
        mul_a      = $signed({2'b00, coef.damping});
        mul_b      = -(MUL_W'(velocity_now));
        state_next = ST_FORCE;
      end
      ST_FORCE:     state_next = ST_DIV_START;
      ST_DIV_START: state_next = ST_DIV;
      ST_DIV: begin
        if (!div_busy) begin
          state_next = ST_MUL_ACC;
        end
      end
      ST_MUL_ACC: begin
        mul_a      = MUL_W'(acc);
        mul_b      = $signed({{(MUL_W-TS_W){1'b0}}, dt});
        state_next = ST_VEL;
      end
      ST_VEL: state_next = ST_MUL_VEL;
      ST_MUL_VEL: begin
        mul_a      = MUL_W'(vel_new);
        mul_b      = $signed({{(MUL_W-TS_W){1'b0}}, dt});
        state_next = ST_POS;
      end
      ST_POS:   state_next = ST_DONE;
      ST_SCRUB: state_next = ST_DONE;
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Update the animator state and the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      value_now    <= '0;
      velocity_now <= '0;
      target_now   <= ONE_VAL;
      scrub_mode   <= 1'b0;
      scrub_amount <= '0;
      out_valid    <= 1'b0;
    end else begin
      // Raise the result flag on a finished step, drop it once taken
      if (state == ST_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ch.valid && out_ch.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_ch.valid) begin
            case (req_func)
              FN_RESTART: begin
                value_now    <= '0;
                target_now   <= ONE_VAL;
                velocity_now <= coef.start_velocity;
                scrub_mode   <= 1'b0;
                scrub_amount <= '0;
              end
              FN_TARGET: begin
                target_now <= in_ch.req.new_target;
                scrub_mode <= 1'b0;
              end
              FN_SCRUB: begin
                scrub_amount <= frac_clamped;
                scrub_mode   <= 1'b1;
              end
              default: ;
            endcase
          end
        end
        ST_VEL: velocity_now <= sat32(ACC_W'(velocity_now) + prod_fl);
        ST_DONE: begin
          if (out_free) begin
            value_now <= settle_hit ? target_now : pos_new;
          end
        end
        default: ;
      endcase
    end
  end

  // Working datapath registers
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        dt   <= in_ch.req.time_step;
        disp <= sat32(ACC_W'(value_now) - ACC_W'(target_now));
      end
      ST_MUL_C: force_part <= prod_fl;
      ST_FORCE: force_sat  <= sat32(force_part + prod_fl);
      ST_DIV: begin
        if (!div_busy) begin
          acc <= sat32(force_sat[FIELD_W-1] ? -quo_ext : quo_ext);
        end
      end
      ST_VEL: vel_new <= sat32(ACC_W'(velocity_now) + prod_fl);
      ST_POS: begin
        pos_new  <= sat32(ACC_W'(value_now) + prod_fl);
        is_scrub <= 1'b0;
      end
      ST_SCRUB: begin
        pos_new  <= sat32(prod_fl);
        is_scrub <= 1'b1;
      end
      ST_DONE: begin
        if (out_free) begin
          out_pos     <= pos_new;
          out_settled <= settle_hit;
        end
      end
      default: ;
    endcase
  end

endmodule

// ===== sv/dsi_regs.sv =====
// Configuration register file with zero-means-default substitution.
// Depends on dsi_pkg and dsi_cfg_if.
module dsi_regs #(
  parameter int FRAC_BITS = 16
) (
  input  logic           clk,
  input  logic           rst,
  dsi_cfg_if.sink        cfg_ch,
  output dsi_pkg::coef_t coef
);
  import dsi_pkg::*;

  localparam logic [COEF_W-1:0] ONE_C   = COEF_W'(1) << FRAC_BITS;
  localparam logic [COEF_W-1:0] STIFF_D = COEF_W'(100) << FRAC_BITS;
  localparam logic [COEF_W-1:0] DAMP_D  = COEF_W'(10) << FRAC_BITS;

  logic [COEF_W-1:0]         mass;
  logic [COEF_W-1:0]         stiffness;
  logic [COEF_W-1:0]         damping;
  logic signed [FIELD_W-1:0] start_velocity;
  logic [THR_W-1:0]          threshold;

  assign cfg_ch.ready = 1'b1;

  // Take one register write per request
  always_ff @(posedge clk) begin
    if (rst) begin
      mass           <= ONE_C;
      stiffness      <= STIFF_D;
      damping        <= DAMP_D;
      start_velocity <= '0;
      threshold      <= THR_RESET;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.req.index)
        CFG_MASS:      mass           <= cfg_ch.req.data[COEF_W-1:0];
        CFG_STIFFNESS: stiffness      <= cfg_ch.req.data[COEF_W-1:0];
        CFG_DAMPING:   damping        <= cfg_ch.req.data[COEF_W-1:0];
        CFG_START_VEL: start_velocity <= $signed(cfg_ch.req.data);
        CFG_THRESHOLD: threshold      <= cfg_ch.req.data[THR_W-1:0];
        default: ;
      endcase
    end
  end

  // Substitute defaults for zero coefficients
  always_comb begin
    coef.mass           = (mass == '0) ? ONE_C : mass;
    coef.stiffness      = (stiffness == '0) ? STIFF_D : stiffness;
    coef.damping        = (damping == '0) ? DAMP_D : damping;
    coef.start_velocity = start_velocity;
    coef.threshold      = threshold;
  end

endmodule

// ===== sv/dsi_mul.sv =====
// Shared signed multiplier with a registered product.
// Depends on dsi_pkg for operand and product widths.
module dsi_mul (
  input  logic                               clk,
  input  logic signed [dsi_pkg::MUL_W-1:0]   a,
  input  logic signed [dsi_pkg::MUL_W-1:0]   b,
  output logic signed [dsi_pkg::PROD_W-1:0]  p
);
  import dsi_pkg::*;

  logic signed [PROD_W-1:0] prod;

  // Full-width signed product of the two operands
  assign prod = a * b;

  // Register the product every cycle
  always_ff @(posedge clk) begin
    p <= prod;
  end

endmodule

// ===== sv/dsi_div.sv =====
// Restoring radix-2 divider on magnitudes, one quotient bit per cycle.
// Depends on dsi_pkg for the divisor width.
module dsi_div #(
  parameter int DW = 48
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [DW-1:0]                 dividend,
  input  logic [dsi_pkg::COEF_W-1:0]    divisor,
  output logic                          busy,
  output logic [DW-1:0]                 quotient
);
  import dsi_pkg::*;

  localparam int CW = $clog2(DW + 1);

  logic [CW-1:0]     cnt;
  logic [COEF_W-1:0] rem;
  logic [DW-1:0]     quo;
  logic [COEF_W:0]   trial;
  logic [COEF_W:0]   diff;
  logic              fits;

  // Trial subtract of the divisor from the shifted partial remainder
  assign trial = {rem, quo[DW-1]};
  assign diff  = trial - {1'b0, divisor};
  assign fits  = (trial >= {1'b0, divisor});

  assign quotient = quo;

  // Count the steps
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CW'(DW);
    end else if (busy) begin
      cnt <= cnt - CW'(1);
      if (cnt == CW'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  // Shift dividend bits out and quotient bits in
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
    end else if (busy) begin
      rem <= fits ? diff[COEF_W-1:0] : trial[COEF_W-1:0];
      quo <= {quo[DW-2:0], fits};
    end
  end

endmodule
